// File: rtl/core/assert_macros.svh
// Concurrent assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("core assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("core assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/pidw_pkg.sv
// Shared widths, constants and types of the PID core.
package pidw_pkg;

	localparam int DATA_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int SUM_W      = 48;
	localparam int LIM_W      = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int NUM_STAGES = 6;

	// angle wrap threshold, 360.0 in Q16.16
	localparam logic signed [DATA_W-1:0] WRAP_LIMIT = DATA_W'(360 * (2 ** FRAC_W));
	localparam logic signed [DATA_W-1:0] WRAP_NEG   = -WRAP_LIMIT;

	localparam logic signed [DATA_W-1:0] ERR_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] ERR_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0]  SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0]  SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP           = 3'd0,
		REG_KI           = 3'd1,
		REG_KD           = 3'd2,
		REG_MAX_INTEGRAL = 3'd3,
		REG_MAX_DRIVE    = 3'd4,
		REG_WRAP_ENABLE  = 3'd5
	} cfg_reg_t;

	// per-stage load strobes and occupancy, stage 1 at bit 0
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] valid;
	} pipe_ctl_t;

endpackage

// File: rtl/core/pidw_if.sv
// Channel interfaces: sample input, result output and configuration writes.
interface pidw_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [pidw_pkg::DATA_W-1:0]  set_point;
	logic signed [pidw_pkg::DATA_W-1:0]  measured;

	modport source(output valid, output set_point, output measured, input ready);
	modport sink(input valid, input set_point, input measured, output ready);
endinterface

interface pidw_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [pidw_pkg::DATA_W-1:0]  drive;
	logic                                drive_clamped;
	logic                                integral_clamped;

	modport source(output valid, output drive, output drive_clamped,
		output integral_clamped, input ready);
	modport sink(input valid, input drive, input drive_clamped,
		input integral_clamped, output ready);
endinterface

interface pidw_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [pidw_pkg::CFG_IDX_W-1:0]      index;
	logic [pidw_pkg::DATA_W-1:0]         data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/core/positional_pid_with_angle_wrap.sv
// An accepted sample enters stage 1 and moves on through stages 2 to 6 in turn.
// One sample per cycle unless stalled; the six-stage pipe ends in a result register,
// so up to five more samples are taken while a finished result waits for its consumer.
// Reset (arst_n low): gains, limits and wrap mode clear to zero, as do the error sum
// and previous error; the pipeline empties and no result is offered.
`include "assert_macros.svh"

module positional_pid_with_angle_wrap (
	input  logic        clk,
	input  logic        arst_n,
	pidw_cfg_if.sink    cfg,
	pidw_in_if.sink     sample,
	pidw_out_if.source  result
);

	localparam int DW = pidw_pkg::DATA_W;
	localparam int FW = pidw_pkg::FRAC_W;
	localparam int LW = pidw_pkg::LIM_W;

	logic signed [DW-1:0]        kp_q;
	logic signed [DW-1:0]        ki_q;
	logic signed [DW-1:0]        kd_q;
	logic [LW-1:0]               max_integral_q;
	logic [LW-1:0]               max_drive_q;
	logic                        wrap_enable_q;

	pidw_pkg::pipe_ctl_t         ctl;
	logic signed [DW-1:0]        err_s3;
	logic signed [pidw_pkg::SUM_W-1:0] sum_s3;
	logic signed [DW:0]          delta_s3;
	logic signed [2*DW-1:0]      pprod_s4;
	logic signed [2*DW-1:0]      iprod_hi_s4;
	logic signed [DW+FW:0]       iprod_lo_s4;
	logic signed [2*DW:0]        dprod_s4;
	logic signed [DW-1:0]        lim_pos;
	logic signed [DW-1:0]        lim_neg;
	logic                        drv_at_lim;
	logic                        drv_in_lim;

	// configuration writes, unknown indexes ignored
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q           <= '0;
			ki_q           <= '0;
			kd_q           <= '0;
			max_integral_q <= '0;
			max_drive_q    <= '0;
			wrap_enable_q  <= 1'b0;
		end else if (cfg.valid) begin
			case (pidw_pkg::cfg_reg_t'(cfg.index))
				pidw_pkg::REG_KP:           kp_q           <= cfg.data;
				pidw_pkg::REG_KI:           ki_q           <= cfg.data;
				pidw_pkg::REG_KD:           kd_q           <= cfg.data;
				pidw_pkg::REG_MAX_INTEGRAL: max_integral_q <= cfg.data[LW-1:0];
				pidw_pkg::REG_MAX_DRIVE:    max_drive_q    <= cfg.data[LW-1:0];
				pidw_pkg::REG_WRAP_ENABLE:  wrap_enable_q  <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	// pipeline control
	pidw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.ctl       (ctl)
	);

	// error, state update
	pidw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.set_point   (sample.set_point),
		.measured    (sample.measured),
		.wrap_enable (wrap_enable_q),
		.err_s3      (err_s3),
		.sum_s3      (sum_s3),
		.delta_s3    (delta_s3)
	);

	// gain products
	pidw_mult u_mult (
		.clk         (clk),
		.ctl         (ctl),
		.kp          (kp_q),
		.ki          (ki_q),
		.kd          (kd_q),
		.err_s3      (err_s3),
		.sum_s3      (sum_s3),
		.delta_s3    (delta_s3),
		.pprod_s4    (pprod_s4),
		.iprod_hi_s4 (iprod_hi_s4),
		.iprod_lo_s4 (iprod_lo_s4),
		.dprod_s4    (dprod_s4)
	);

	// terms, clamps, result register
	pidw_back u_back (
		.clk                 (clk),
		.ctl                 (ctl),
		.max_integral        (max_integral_q),
		.max_drive           (max_drive_q),
		.pprod_s4            (pprod_s4),
		.iprod_hi_s4         (iprod_hi_s4),
		.iprod_lo_s4         (iprod_lo_s4),
		.dprod_s4            (dprod_s4),
		.drive_s6            (result.drive),
		.drive_clamped_s6    (result.drive_clamped),
		.integral_clamped_s6 (result.integral_clamped)
	);

	// drive limits as signed values for the checks below
	assign lim_pos    = $signed({1'b0, max_drive_q});
	assign lim_neg    = -lim_pos;
	assign drv_at_lim = (result.drive == lim_pos) || (result.drive == lim_neg);
	assign drv_in_lim = (result.drive < lim_pos) && (result.drive > lim_neg);

	`ASSERT_IMP(a_clamped_at_limit, clk, arst_n, result.valid && result.drive_clamped, drv_at_lim)
	`ASSERT_IMP(a_free_inside_limit, clk, arst_n, result.valid && !result.drive_clamped, drv_in_lim)
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, sample.valid && sample.ready, ctl.valid[0])

endmodule

// File: rtl/core/pidw_ctrl.sv
// Pipeline flow control: stage occupancy, load strobes and handshakes.
module pidw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pidw_pkg::pipe_ctl_t   ctl
);

	localparam int N = pidw_pkg::NUM_STAGES;

	logic [N-1:0] valid_q;
	logic [N-1:0] en;
	logic [N-1:0] load;

	// a stage may take a beat when empty or when it passes its own on
	always_comb begin
		en[N-1] = !valid_q[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
		load[0] = en[0] && in_valid;
		for (int k = 1; k < N; k++) begin
			load[k] = en[k] && valid_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_q[N-1];
	assign ctl.load  = load;
	assign ctl.valid = valid_q;

endmodule

// File: rtl/core/pidw_front.sv
// Input register, error with saturation and angle wrap, error sum and delta.
module pidw_front (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  pidw_pkg::pipe_ctl_t                     ctl,
	input  logic signed [pidw_pkg::DATA_W-1:0]      set_point,
	input  logic signed [pidw_pkg::DATA_W-1:0]      measured,
	input  logic                                    wrap_enable,
	output logic signed [pidw_pkg::DATA_W-1:0]      err_s3,
	output logic signed [pidw_pkg::SUM_W-1:0]       sum_s3,
	output logic signed [pidw_pkg::DATA_W:0]        delta_s3
);

	localparam int DW = pidw_pkg::DATA_W;
	localparam int SW = pidw_pkg::SUM_W;

	logic signed [DW-1:0] set_point_s1;
	logic signed [DW-1:0] measured_s1;
	logic signed [DW:0]   diff;
	logic signed [DW-1:0] err_sat;
	logic signed [DW-1:0] err_wrap;
	logic signed [DW-1:0] err_s2;
	logic signed [SW:0]   sum_ext;
	logic signed [SW-1:0] sum_next;
	logic signed [DW:0]   delta;
	logic signed [DW-1:0] prev_err_q;
	logic signed [SW-1:0] err_sum_q;

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			set_point_s1 <= set_point;
			measured_s1  <= measured;
		end
	end

	// stage 2: saturated difference, then optional wrap by 360
	always_comb begin
		diff = {set_point_s1[DW-1], set_point_s1} - {measured_s1[DW-1], measured_s1};
		if (diff[DW] != diff[DW-1]) begin
			err_sat = diff[DW] ? pidw_pkg::ERR_MIN : pidw_pkg::ERR_MAX;
		end else begin
			err_sat = diff[DW-1:0];
		end
		if (wrap_enable && (err_sat > pidw_pkg::WRAP_LIMIT)) begin
			err_wrap = err_sat - pidw_pkg::WRAP_LIMIT;
		end else if (wrap_enable && (err_sat < pidw_pkg::WRAP_NEG)) begin
			err_wrap = err_sat + pidw_pkg::WRAP_LIMIT;
		end else begin
			err_wrap = err_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			err_s2 <= err_wrap;
		end
	end

	// stage 3: saturating sum and difference to the previous error
	always_comb begin
		sum_ext = {err_sum_q[SW-1], err_sum_q} + {{(SW-DW+1){err_s2[DW-1]}}, err_s2};
		if (sum_ext[SW] != sum_ext[SW-1]) begin
			sum_next = sum_ext[SW] ? pidw_pkg::SUM_MIN : pidw_pkg::SUM_MAX;
		end else begin
			sum_next = sum_ext[SW-1:0];
		end
		delta = {err_s2[DW-1], err_s2} - {prev_err_q[DW-1], prev_err_q};
	end

	// controller state doubles as the stage 3 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_sum_q  <= '0;
			prev_err_q <= '0;
		end else if (ctl.load[2]) begin
			err_sum_q  <= sum_next;
			prev_err_q <= err_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			delta_s3 <= delta;
		end
	end

	assign err_s3 = prev_err_q;
	assign sum_s3 = err_sum_q;

endmodule

// File: rtl/core/pidw_mult.sv
// Gain multipliers: P, D and the split integral product, all registered.
module pidw_mult (
	input  logic                                          clk,
	input  pidw_pkg::pipe_ctl_t                           ctl,
	input  logic signed [pidw_pkg::DATA_W-1:0]            kp,
	input  logic signed [pidw_pkg::DATA_W-1:0]            ki,
	input  logic signed [pidw_pkg::DATA_W-1:0]            kd,
	input  logic signed [pidw_pkg::DATA_W-1:0]            err_s3,
	input  logic signed [pidw_pkg::SUM_W-1:0]             sum_s3,
	input  logic signed [pidw_pkg::DATA_W:0]              delta_s3,
	output logic signed [2*pidw_pkg::DATA_W-1:0]          pprod_s4,
	output logic signed [2*pidw_pkg::DATA_W-1:0]          iprod_hi_s4,
	output logic signed [pidw_pkg::DATA_W+pidw_pkg::FRAC_W:0] iprod_lo_s4,
	output logic signed [2*pidw_pkg::DATA_W:0]            dprod_s4
);

	localparam int DW  = pidw_pkg::DATA_W;
	localparam int FW  = pidw_pkg::FRAC_W;
	localparam int SW  = pidw_pkg::SUM_W;
	localparam int PPW = 2 * DW;       // P and high integral product width
	localparam int ILW = DW + FW + 1;  // low integral product width
	localparam int DPW = 2 * DW + 1;   // D product width

	logic signed [SW-FW-1:0] sum_hi;
	logic signed [FW:0]      sum_lo;

	// sum = hi * 2^16 + lo with lo unsigned
	assign sum_hi = $signed(sum_s3[SW-1:FW]);
	assign sum_lo = $signed({1'b0, sum_s3[FW-1:0]});

	// stage 4
	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			pprod_s4    <= PPW'(kp) * PPW'(err_s3);
			iprod_hi_s4 <= PPW'(ki) * PPW'(sum_hi);
			iprod_lo_s4 <= ILW'(ki) * ILW'(sum_lo);
			dprod_s4    <= DPW'(kd) * DPW'(delta_s3);
		end
	end

endmodule

// File: rtl/core/pidw_back.sv
// Term scaling, integral clamp, total and drive clamp into the result register.
module pidw_back (
	input  logic                                          clk,
	input  pidw_pkg::pipe_ctl_t                           ctl,
	input  logic [pidw_pkg::LIM_W-1:0]                    max_integral,
	input  logic [pidw_pkg::LIM_W-1:0]                    max_drive,
	input  logic signed [2*pidw_pkg::DATA_W-1:0]          pprod_s4,
	input  logic signed [2*pidw_pkg::DATA_W-1:0]          iprod_hi_s4,
	input  logic signed [pidw_pkg::DATA_W+pidw_pkg::FRAC_W:0] iprod_lo_s4,
	input  logic signed [2*pidw_pkg::DATA_W:0]            dprod_s4,
	output logic signed [pidw_pkg::DATA_W-1:0]            drive_s6,
	output logic                                          drive_clamped_s6,
	output logic                                          integral_clamped_s6
);

	localparam int DW  = pidw_pkg::DATA_W;
	localparam int FW  = pidw_pkg::FRAC_W;
	localparam int LW  = pidw_pkg::LIM_W;
	localparam int PW  = 2 * DW - FW;      // P term width
	localparam int DTW = 2 * DW + 1 - FW;  // D term width
	localparam int ILW = DW + 1;           // scaled low integral part
	localparam int IW  = 2 * DW;           // full integral term
	localparam int TW  = DTW + 2;          // total, with headroom

	logic signed [IW-1:0]  iterm;
	logic signed [IW-1:0]  ilim_pos;
	logic signed [IW-1:0]  ilim_neg;
	logic signed [DW-1:0]  iterm_c;
	logic                  iclamp;
	logic signed [PW-1:0]  pterm_s5;
	logic signed [DTW-1:0] dterm_s5;
	logic signed [DW-1:0]  iterm_s5;
	logic                  iclamp_s5;
	logic signed [TW-1:0]  total;
	logic signed [TW-1:0]  dlim_pos;
	logic signed [TW-1:0]  dlim_neg;
	logic signed [DW-1:0]  drive_c;
	logic                  dclamp;

	// stage 5: integral term ki*hi + floor(ki*lo / 2^16), then clamp
	always_comb begin
		iterm    = iprod_hi_s4 +
			{{(IW-ILW){iprod_lo_s4[DW+FW]}}, iprod_lo_s4[DW+FW:FW]};
		ilim_pos = {{(IW-LW){1'b0}}, max_integral};
		ilim_neg = -ilim_pos;
		iclamp   = 1'b1;
		if (iterm >= ilim_pos) begin
			iterm_c = ilim_pos[DW-1:0];
		end else if (iterm <= ilim_neg) begin
			iterm_c = ilim_neg[DW-1:0];
		end else begin
			iterm_c = iterm[DW-1:0];
			iclamp  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			pterm_s5  <= pprod_s4[2*DW-1:FW];
			dterm_s5  <= dprod_s4[2*DW:FW];
			iterm_s5  <= iterm_c;
			iclamp_s5 <= iclamp;
		end
	end

	// stage 6: sum of terms and drive clamp
	always_comb begin
		total    = {{(TW-PW){pterm_s5[PW-1]}}, pterm_s5} +
			{{(TW-DTW){dterm_s5[DTW-1]}}, dterm_s5} +
			{{(TW-DW){iterm_s5[DW-1]}}, iterm_s5};
		dlim_pos = {{(TW-LW){1'b0}}, max_drive};
		dlim_neg = -dlim_pos;
		dclamp   = 1'b1;
		if (total >= dlim_pos) begin
			drive_c = dlim_pos[DW-1:0];
		end else if (total <= dlim_neg) begin
			drive_c = dlim_neg[DW-1:0];
		end else begin
			drive_c = total[DW-1:0];
			dclamp  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			drive_s6            <= drive_c;
			drive_clamped_s6    <= dclamp;
			integral_clamped_s6 <= iclamp_s5;
		end
	end

endmodule

// File: test/pidw_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the PID core: mirrors gains, limits and loop state, checks every result beat.
module pidw_scoreboard (
	input  logic clk,
	input  logic arst_n,
	pidw_cfg_if  cfg,
	pidw_in_if   smp,
	pidw_out_if  res,
	output int   fail_count,
	output int   pending
);

	localparam int DATA_W = pidw_pkg::DATA_W;
	localparam int FRAC_W = pidw_pkg::FRAC_W;
	localparam int SUM_W  = pidw_pkg::SUM_W;
	localparam int LIM_W  = pidw_pkg::LIM_W;
	localparam int IPW    = SUM_W + DATA_W;

	typedef struct {
		logic signed [DATA_W-1:0] drive;
		logic                     drive_clamped;
		logic                     integral_clamped;
	} pid_result_t;

	pid_result_t pending_drives[$];
	pid_result_t want;

	// mirrored registers and loop state
	logic signed [DATA_W-1:0] kp_gain, ki_gain, kd_gain;
	logic [LIM_W-1:0]         integral_limit, drive_limit;
	logic                     wrap_on;
	logic signed [DATA_W-1:0] prev_error;
	logic signed [SUM_W-1:0]  error_sum;
	int                       mismatches;

	// symmetric clamp, a value sitting on the limit counts as a hit
	function automatic longint clamp_sym(input longint v, input longint lim, output logic hit);
		hit = 1'b0;
		if (v >= lim) begin
			v = lim;
			hit = 1'b1;
		end
		if (v <= -lim) begin
			v = -lim;
			hit = 1'b1;
		end
		return v;
	endfunction

	// one control step: updates the sum and previous error, returns the drive beat
	function automatic pid_result_t next_drive(input logic signed [DATA_W-1:0] sp,
			input logic signed [DATA_W-1:0] ms);
		longint                  err, acc, delta, pterm, iterm, dterm, total;
		logic signed [IPW-1:0]   iprod;
		logic                    ihit, dhit;
		pid_result_t             r;
		err = longint'(sp) - longint'(ms);
		if (err > longint'(pidw_pkg::ERR_MAX))
			err = longint'(pidw_pkg::ERR_MAX);
		if (err < longint'(pidw_pkg::ERR_MIN))
			err = longint'(pidw_pkg::ERR_MIN);
		if (wrap_on) begin
			if (err > longint'(pidw_pkg::WRAP_LIMIT))
				err = err - longint'(pidw_pkg::WRAP_LIMIT);
			else if (err < longint'(pidw_pkg::WRAP_NEG))
				err = err + longint'(pidw_pkg::WRAP_LIMIT);
		end

		// saturating running sum
		acc = longint'(error_sum) + err;
		if (acc > longint'(pidw_pkg::SUM_MAX))
			acc = longint'(pidw_pkg::SUM_MAX);
		if (acc < longint'(pidw_pkg::SUM_MIN))
			acc = longint'(pidw_pkg::SUM_MIN);
		error_sum = SUM_W'(acc);

		delta = err - longint'(prev_error);

		// exact products, floor shift back to Q16.16
		pterm = (longint'(kp_gain) * err) >>> FRAC_W;
		iprod = IPW'(ki_gain) * IPW'(error_sum);
		iterm = longint'(iprod >>> FRAC_W);
		iterm = clamp_sym(iterm, longint'(integral_limit), ihit);
		dterm = (longint'(kd_gain) * delta) >>> FRAC_W;
		total = clamp_sym(pterm + iterm + dterm, longint'(drive_limit), dhit);

		prev_error = DATA_W'(err);
		r.drive = DATA_W'(total);
		r.drive_clamped = dhit;
		r.integral_clamped = ihit;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_gain = '0;
			ki_gain = '0;
			kd_gain = '0;
			integral_limit = '0;
			drive_limit = '0;
			wrap_on = 1'b0;
			prev_error = '0;
			error_sum = '0;
			pending_drives.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					pidw_pkg::REG_KP:           kp_gain = cfg.data;
					pidw_pkg::REG_KI:           ki_gain = cfg.data;
					pidw_pkg::REG_KD:           kd_gain = cfg.data;
					pidw_pkg::REG_MAX_INTEGRAL: integral_limit = cfg.data[LIM_W-1:0];
					pidw_pkg::REG_MAX_DRIVE:    drive_limit = cfg.data[LIM_W-1:0];
					pidw_pkg::REG_WRAP_ENABLE:  wrap_on = cfg.data[0];
					default: ;
				endcase
			end

			// sample beat: predict
			if (smp.valid && smp.ready)
				pending_drives.push_back(next_drive(smp.set_point, smp.measured));

			// result beat: compare with the oldest prediction
			if (res.valid && res.ready) begin
				if (pending_drives.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: drive %0d flags %b/%b",
							res.drive, res.drive_clamped, res.integral_clamped);
				end else begin
					want = pending_drives.pop_front();
					if (res.drive !== want.drive || res.drive_clamped !== want.drive_clamped
							|| res.integral_clamped !== want.integral_clamped) begin
						mismatches++;
						if (mismatches <= 10)
							$display("drive mismatch: want %0d/%b/%b got %0d/%b/%b",
								want.drive, want.drive_clamped, want.integral_clamped,
								res.drive, res.drive_clamped, res.integral_clamped);
					end
				end
			end

			fail_count <= mismatches;
			pending <= pending_drives.size();
		end
	end

endmodule

// File: test/positional_pid_with_angle_wrap_test.sv
`timescale 1ns / 1ps
// Top of the PID core test: clock, reset, register setup, sample traffic and verdict.
module positional_pid_with_angle_wrap_test;

	localparam int DATA_W    = pidw_pkg::DATA_W;
	localparam int FRAC_W    = pidw_pkg::FRAC_W;
	localparam int LIM_W     = pidw_pkg::LIM_W;
	localparam int CFG_IDX_W = pidw_pkg::CFG_IDX_W;

	localparam logic signed [DATA_W-1:0] ERR_MAX    = pidw_pkg::ERR_MAX;
	localparam logic signed [DATA_W-1:0] ERR_MIN    = pidw_pkg::ERR_MIN;
	localparam logic signed [DATA_W-1:0] WRAP_LIMIT = pidw_pkg::WRAP_LIMIT;
	localparam logic signed [DATA_W-1:0] WRAP_NEG   = pidw_pkg::WRAP_NEG;

	localparam int CFG_REG_COUNT   = 6;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int DRAIN_CYCLES    = 20;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int RANDOM_PHASES   = 11;
	localparam int HOLD_PHASE      = 3;
	localparam int SUM_POS_ITEMS   = 30;
	localparam int SUM_NEG_ITEMS   = 30;

	localparam logic signed [DATA_W-1:0] ONE_Q      = 32'sh0001_0000;
	localparam logic signed [DATA_W-1:0] DRIVE_EDGE = 32'sh0064_0000;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

	logic     clk;
	logic     arst_n;
	int       fail_count;
	int       pending;
	int       cycle_cnt = 0;
	int       burst_left = 0;
	rx_mode_t rx_mode = RX_ALWAYS;
	bit       tx_idle = 1'b0;
	bit       hold_off = 1'b0;

	pidw_cfg_if cfg_ch();
	pidw_in_if  smp_ch();
	pidw_out_if res_ch();

	positional_pid_with_angle_wrap uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (smp_ch),
		.result (res_ch)
	);

	pidw_scoreboard sb (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.smp        (smp_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: stall pattern per phase, plus one long hold-off on request
	initial begin : receiver
		int rx_tick;
		rx_tick = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_tick++;
			if (hold_off) begin
				hold_off = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			case (rx_mode)
				RX_ALWAYS:  res_ch.ready <= 1'b1;
				RX_RANDOM:  res_ch.ready <= ($urandom_range(0, 2) != 0);
				RX_PATTERN: res_ch.ready <= ((rx_tick % 9) < 5);
				default:    res_ch.ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// one register write beat; valid is left high for the caller
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		logic rdy;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do begin
			@(negedge clk);
			rdy = cfg_ch.ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	// full register set, sometimes with a stray write to an unused index
	task automatic configure(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
			input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] mi,
			input logic [DATA_W-1:0] md, input logic [DATA_W-1:0] wr);
		write_reg(pidw_pkg::REG_KP, kp);
		write_reg(pidw_pkg::REG_KI, ki);
		write_reg(pidw_pkg::REG_KD, kd);
		if ($urandom_range(0, 1))
			write_reg(CFG_IDX_W'(CFG_REG_COUNT
				+ $urandom_range(0, 2 ** CFG_IDX_W - 1 - CFG_REG_COUNT)), $urandom());
		write_reg(pidw_pkg::REG_MAX_INTEGRAL, mi);
		write_reg(pidw_pkg::REG_MAX_DRIVE, md);
		write_reg(pidw_pkg::REG_WRAP_ENABLE, wr);
		cfg_ch.valid <= 1'b0;
	endtask

	// one sample beat; bursts of random length with gaps when tx_idle is set
	task automatic send_sample(input logic signed [DATA_W-1:0] sp,
			input logic signed [DATA_W-1:0] ms);
		logic rdy;
		int   gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = tx_idle ? $urandom_range(1, 12) : 0;
			if (gap > 0) begin
				smp_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		smp_ch.valid <= 1'b1;
		smp_ch.set_point <= sp;
		smp_ch.measured <= ms;
		do begin
			@(negedge clk);
			rdy = smp_ch.ready;
			@(posedge clk);
		end while (!rdy);
		burst_left--;
	endtask

	// stop offering and wait until every predicted beat has come back
	task automatic finish_phase();
		smp_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return $urandom();
			1:       return $urandom_range(0, 2 ** 19) - 2 ** 18;
			2:       return ERR_MAX;
			3:       return ERR_MIN;
			4:       return '0;
			default: return $urandom_range(0, 2 ** 17) - 2 ** 16;
		endcase
	endfunction

	// limit in the low 31 bits, random junk in the unused top bit
	function automatic logic [DATA_W-1:0] pick_limit();
		logic [LIM_W-1:0] lim;
		logic             spare;
		spare = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 4))
			0:       lim = LIM_W'($urandom());
			1:       lim = LIM_W'($urandom_range(0, 2 ** 24));
			2:       lim = '1;
			3:       lim = '0;
			default: lim = LIM_W'($urandom_range(0, 2 ** 28));
		endcase
		return {spare, lim};
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_extreme();
		case ($urandom_range(0, 5))
			0:       return ERR_MAX;
			1:       return ERR_MIN;
			2:       return '0;
			3:       return '1;
			4:       return 1;
			default: return WRAP_LIMIT;
		endcase
	endfunction

	initial begin : stimulus
		logic signed [DATA_W-1:0] sp, ms, err;
		int                       n;
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		smp_ch.valid <= 1'b0;
		smp_ch.set_point <= '0;
		smp_ch.measured <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: zero gains and zero limits, so both clamps report on every beat
		send_sample(0, 0);
		send_sample(ERR_MAX, ERR_MIN);
		send_sample(ONE_Q, 0);
		send_sample(ERR_MIN, ERR_MAX);
		finish_phase();

		// unit P gain: total landing exactly on the drive limit counts as clamped
		configure(ONE_Q, '0, '0, '0, DRIVE_EDGE, '0);
		send_sample(DRIVE_EDGE, 0);
		send_sample(0, DRIVE_EDGE);
		send_sample(DRIVE_EDGE - 1, 0);
		send_sample(0, DRIVE_EDGE - 1);
		send_sample(DRIVE_EDGE + 1, 0);
		send_sample(0, 0);
		finish_phase();

		// extreme gains, widest limits with junk top bits, wrap on
		tx_idle = 1'b1;
		configure(ERR_MAX, ERR_MIN, ERR_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(ERR_MAX, ERR_MIN);
		send_sample(ERR_MIN, ERR_MAX);
		send_sample(WRAP_LIMIT, 0);
		send_sample(WRAP_LIMIT + 1, 0);
		send_sample(0, WRAP_LIMIT);
		send_sample(0, WRAP_LIMIT + 1);
		send_sample(ERR_MAX, 0);
		send_sample(ERR_MIN, 0);
		send_sample(0, ERR_MIN);
		send_sample('1, '1);
		finish_phase();

		// random settings, mostly angle-like traffic around the wrap threshold
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			tx_idle = ($urandom_range(0, 3) != 0);
			configure(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
				$urandom());
			if (ph == HOLD_PHASE) begin
				// keep offering while the result side holds off, so the pipe backs up
				tx_idle = 1'b0;
				hold_off = 1'b1;
			end
			n = $urandom_range(55, 85);
			repeat (n) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						sp = $urandom_range(0, 1440 * 2 ** FRAC_W) - 720 * 2 ** FRAC_W;
						ms = $urandom_range(0, 1440 * 2 ** FRAC_W) - 720 * 2 ** FRAC_W;
					end
					4, 5: begin
						ms = $urandom_range(0, 2 ** 21) - 2 ** 20;
						err = ($urandom_range(0, 1) ? WRAP_LIMIT : WRAP_NEG)
							+ ($urandom_range(0, 4) - 2);
						sp = ms + err;
					end
					6, 7: begin
						sp = $urandom();
						ms = $urandom();
					end
					8: begin
						sp = pick_extreme();
						ms = pick_extreme();
					end
					default: begin
						sp = $urandom_range(0, 2 ** 19) - 2 ** 18;
						ms = $urandom_range(0, 2 ** 19) - 2 ** 18;
					end
				endcase
				send_sample(sp, ms);
			end
			finish_phase();
		end

		// full-rate run with the largest errors, first positive, then negative
		rx_mode = RX_ALWAYS;
		tx_idle = 1'b0;
		configure(ONE_Q, 32'h0000_0001, ONE_Q, 32'h7FFF_FFFF, 32'h4000_0000, '0);
		repeat (SUM_POS_ITEMS) send_sample(ERR_MAX, ERR_MIN);
		repeat (SUM_NEG_ITEMS) send_sample(ERR_MIN, ERR_MAX);
		finish_phase();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
